### design/gbn_pkg.sv
// gbn_pkg: shared constants, opcode codes, command/status structs and modular
// index helpers for the go-back-N sender. No dependencies.
package gbn_pkg;

  localparam int WINDOW       = 4;
  localparam int SEQ_RANGE    = 8;
  localparam int PAYLOAD_BITS = 64;

  localparam int SEQ_W  = $clog2(SEQ_RANGE);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int OP_W   = 2;
  localparam int SUM_W  = ((SEQ_W > CNT_W) ? SEQ_W : CNT_W) + 1;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [PAYLOAD_BITS-1:0] word_t;

  localparam op_t OP_SEND    = op_t'(0);
  localparam op_t OP_ACK     = op_t'(1);
  localparam op_t OP_TIMEOUT = op_t'(2);

  // controller -> datapath
  typedef struct packed {
    logic exec;   // take the input word and load its first result
    logic step;   // load the next replayed packet
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic multi;      // more than one packet outstanding
    logic final_pkt;  // the replay index points at the newest packet
  } status_t;

  // ring slot of head + off, off no larger than WINDOW
  function automatic slot_t slot_add(slot_t head, cnt_t off);
    sum_t s;
    s = sum_t'(head) + sum_t'(off);
    if (s >= sum_t'(WINDOW)) s = s - sum_t'(WINDOW);
    return s[SLOT_W-1:0];
  endfunction

  // a + off modulo the sequence range, off no larger than the range
  function automatic seq_t seq_add(seq_t a, cnt_t off);
    sum_t s;
    s = sum_t'(a) + sum_t'(off);
    if (s >= sum_t'(SEQ_RANGE)) s = s - sum_t'(SEQ_RANGE);
    return s[SEQ_W-1:0];
  endfunction

  // a - b modulo the sequence range
  function automatic seq_t seq_sub(seq_t a, seq_t b);
    sum_t s;
    s = sum_t'(a) + sum_t'(SEQ_RANGE) - sum_t'(b);
    if (s >= sum_t'(SEQ_RANGE)) s = s - sum_t'(SEQ_RANGE);
    return s[SEQ_W-1:0];
  endfunction

endpackage

### design/go_back_n_sender_top.sv
// go_back_n_sender_top: go-back-N sender window, top level.
// Depends on gbn_pkg, gbn_ctrl and gbn_dp.
//
//  channel | handshake            | word
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | opcode, payload, ack_number,
//          |                      | ack_checksum_ok, timer_seq
//  out     | out_valid / out_ready| accepted, window_full, packet_valid,
//          |                      | packet_seq, packet_payload, stop_timer,
//          |                      | stop_seq, start_timer, start_seq, last
//
// Send, ack and an empty-window timeout each yield one word. A timeout with N
// packets stored yields N words, one per cycle while out_ready is high, out of
// the single result register; no input is taken until the last is loaded.
// The input side is ready while idle and the result register is empty or taken.
// Reset (rst, synchronous) empties the window: base, next sequence and count
// at zero. Store contents are undefined until written and are only read
// while they hold an outstanding packet.
// A stall on out_ready holds the result word and the replay in place.
module go_back_n_sender_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gbn_pkg::op_t          opcode,
  input  gbn_pkg::word_t        payload,
  input  gbn_pkg::seq_t         ack_number,
  input  logic                  ack_checksum_ok,
  input  gbn_pkg::seq_t         timer_seq,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  accepted,
  output logic                  window_full,
  output logic                  packet_valid,
  output gbn_pkg::seq_t         packet_seq,
  output gbn_pkg::word_t        packet_payload,
  output logic                  stop_timer,
  output gbn_pkg::seq_t         stop_seq,
  output logic                  start_timer,
  output gbn_pkg::seq_t         start_seq,
  output logic                  last
);

  gbn_pkg::cmd_t    cmd;
  gbn_pkg::status_t status;

  // handshake and replay sequencing
  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // window state, packet store and result word
  gbn_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .opcode          (opcode),
    .payload         (payload),
    .ack_number      (ack_number),
    .ack_checksum_ok (ack_checksum_ok),
    .timer_seq       (timer_seq),
    .accepted        (accepted),
    .window_full     (window_full),
    .packet_valid    (packet_valid),
    .packet_seq      (packet_seq),
    .packet_payload  (packet_payload),
    .stop_timer      (stop_timer),
    .stop_seq        (stop_seq),
    .start_timer     (start_timer),
    .start_seq       (start_seq),
    .last            (last)
  );

endmodule

### design/gbn_ctrl.sv
// gbn_ctrl: handshake and replay state machine of the go-back-N sender.
// Depends on gbn_pkg.
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbn_pkg::op_t      opcode,
  output logic              out_valid,
  input  logic              out_ready,
  output gbn_pkg::cmd_t     cmd,
  input  gbn_pkg::status_t  status
);

  typedef enum logic {S_IDLE, S_REPLAY} state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  always_comb begin
    cmd.exec = in_valid && in_ready;
    cmd.step = (state == S_REPLAY) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec || cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.exec && opcode == gbn_pkg::OP_TIMEOUT && status.multi) begin
            state <= S_REPLAY;
          end
        end
        S_REPLAY: begin
          if (cmd.step && status.final_pkt) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_replay_holds_word: assert property (@(posedge clk) disable iff (rst)
    state == S_REPLAY |-> out_valid)
    else $error("replay state without a pending result word");
  a_exec_step_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec && cmd.step))
    else $error("exec and replay step issued together");
`endif

endmodule

### design/gbn_dp.sv
// gbn_dp: window store, sequence state and result register of the go-back-N
// sender. Depends on gbn_pkg.
module gbn_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  gbn_pkg::cmd_t            cmd,
  output gbn_pkg::status_t         status,
  input  gbn_pkg::op_t             opcode,
  input  gbn_pkg::word_t           payload,
  input  gbn_pkg::seq_t            ack_number,
  input  logic                     ack_checksum_ok,
  input  gbn_pkg::seq_t            timer_seq,
  output logic                     accepted,
  output logic                     window_full,
  output logic                     packet_valid,
  output gbn_pkg::seq_t            packet_seq,
  output gbn_pkg::word_t           packet_payload,
  output logic                     stop_timer,
  output gbn_pkg::seq_t            stop_seq,
  output logic                     start_timer,
  output gbn_pkg::seq_t            start_seq,
  output logic                     last
);

  gbn_pkg::word_t store [gbn_pkg::WINDOW];

  gbn_pkg::seq_t  base_seq, base_seq_next;
  gbn_pkg::seq_t  next_seq, next_seq_next;
  gbn_pkg::cnt_t  outstanding, outstanding_next;
  gbn_pkg::slot_t head, head_next;
  gbn_pkg::cnt_t  rp_idx;
  gbn_pkg::seq_t  ts_reg;

  gbn_pkg::cnt_t  idx_sel;
  gbn_pkg::seq_t  ts_sel;
  gbn_pkg::slot_t rd_slot, wr_slot;
  gbn_pkg::seq_t  ack_dist, dup_seq;
  logic           ack_ok, replay, fin, wr_en;

  logic           r_acc, r_pv, r_stop, r_start;
  gbn_pkg::seq_t  r_pseq, r_sseq, r_tseq;
  gbn_pkg::word_t r_pay;

  assign status.multi     = outstanding > gbn_pkg::cnt_t'(1);
  assign status.final_pkt = (rp_idx + gbn_pkg::cnt_t'(1)) == outstanding;

  always_comb begin
    base_seq_next    = base_seq;
    next_seq_next    = next_seq;
    outstanding_next = outstanding;
    head_next        = head;
    wr_en            = 1'b0;
    r_acc   = 1'b0;
    r_pv    = 1'b0;
    r_pseq  = '0;
    r_pay   = '0;
    r_stop  = 1'b0;
    r_sseq  = '0;
    r_start = 1'b0;
    r_tseq  = '0;

    idx_sel  = cmd.exec ? '0 : rp_idx;
    ts_sel   = cmd.exec ? timer_seq : ts_reg;
    rd_slot  = gbn_pkg::slot_add(head, idx_sel);
    wr_slot  = gbn_pkg::slot_add(head, outstanding);
    fin      = (idx_sel + gbn_pkg::cnt_t'(1)) == outstanding;
    ack_dist = gbn_pkg::seq_sub(ack_number, base_seq);
    dup_seq  = gbn_pkg::seq_sub(base_seq, gbn_pkg::seq_t'(1));
    ack_ok   = ack_checksum_ok && (ack_number != dup_seq) &&
               (gbn_pkg::sum_t'(ack_dist) < gbn_pkg::sum_t'(outstanding));
    replay   = cmd.step ||
               (cmd.exec && opcode == gbn_pkg::OP_TIMEOUT && outstanding != '0);

    if (replay) begin
      // one stored packet, oldest first; stop rides on the first, start on the last
      r_pv   = 1'b1;
      r_pseq = gbn_pkg::seq_add(base_seq, idx_sel);
      r_pay  = store[rd_slot];
      if (idx_sel == '0) begin
        r_stop = 1'b1;
        r_sseq = ts_sel;
      end
      if (fin) begin
        r_start = 1'b1;
        r_tseq  = ts_sel;
      end
    end else if (cmd.exec) begin
      case (opcode)
        gbn_pkg::OP_SEND: begin
          if (outstanding < gbn_pkg::cnt_t'(gbn_pkg::WINDOW)) begin
            wr_en            = 1'b1;
            outstanding_next = outstanding + gbn_pkg::cnt_t'(1);
            next_seq_next    = gbn_pkg::seq_add(next_seq, gbn_pkg::cnt_t'(1));
            r_acc  = 1'b1;
            r_pv   = 1'b1;
            r_pseq = next_seq;
            r_pay  = payload;
            if (outstanding == '0) begin
              r_start = 1'b1;
              r_tseq  = next_seq;
            end
          end
        end
        gbn_pkg::OP_ACK: begin
          if (ack_ok) begin
            // slide past the acked number
            outstanding_next = outstanding - gbn_pkg::cnt_t'(ack_dist) -
                               gbn_pkg::cnt_t'(1);
            head_next     = gbn_pkg::slot_add(head,
                              gbn_pkg::cnt_t'(ack_dist) + gbn_pkg::cnt_t'(1));
            base_seq_next = gbn_pkg::seq_add(ack_number, gbn_pkg::cnt_t'(1));
            r_stop = 1'b1;
            r_sseq = base_seq;
            if (outstanding_next != '0) begin
              r_start = 1'b1;
              r_tseq  = base_seq_next;
            end
          end
        end
        gbn_pkg::OP_TIMEOUT: begin
          // empty window: restart on the expired tag
          r_stop  = 1'b1;
          r_sseq  = ts_sel;
          r_start = 1'b1;
          r_tseq  = ts_sel;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_slot] <= payload;
    end
    if (cmd.exec || cmd.step) begin
      accepted       <= r_acc;
      window_full    <= outstanding_next >= gbn_pkg::cnt_t'(gbn_pkg::WINDOW);
      packet_valid   <= r_pv;
      packet_seq     <= r_pseq;
      packet_payload <= r_pay;
      stop_timer     <= r_stop;
      stop_seq       <= r_sseq;
      start_timer    <= r_start;
      start_seq      <= r_tseq;
      last           <= !replay || fin;
    end
    if (cmd.exec) begin
      ts_reg <= timer_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq    <= '0;
      next_seq    <= '0;
      outstanding <= '0;
      head        <= '0;
      rp_idx      <= '0;
    end else begin
      base_seq    <= base_seq_next;
      next_seq    <= next_seq_next;
      outstanding <= outstanding_next;
      head        <= head_next;
      if (cmd.exec) begin
        rp_idx <= gbn_pkg::cnt_t'(1);
      end else if (cmd.step) begin
        rp_idx <= rp_idx + gbn_pkg::cnt_t'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= gbn_pkg::cnt_t'(gbn_pkg::WINDOW))
    else $error("outstanding count beyond window");
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (rp_idx < outstanding) && $stable(outstanding))
    else $error("replay step past the stored packets");
`endif

endmodule
